// ===== sv/ndd_pkg.sv =====
// Shared widths, constants and types for the divided-difference evaluator.
package ndd_pkg;
  localparam int MAX_POINTS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int DW         = 32;
  localparam int DIFF_W     = DW + 1;
  localparam int NUM_W      = DIFF_W + FRAC_BITS;
  localparam int DIV_CNT_W  = $clog2(NUM_W + 1);

  localparam logic signed [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0] Q_ONE = DW'(1) << FRAC_BITS;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_DUP = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  typedef logic signed [DW-1:0] word_t;

  typedef struct packed {
    word_t value;
    logic  sat;
  } sat_word_t;

  // Clamp a 33-bit exact sum or difference to 32 bits.
  function automatic sat_word_t sat_diff(input logic signed [DIFF_W-1:0] d);
    sat_word_t r;
    if (d[DIFF_W-1] != d[DIFF_W-2]) begin
      r.value = d[DIFF_W-1] ? S_MIN : S_MAX;
      r.sat   = 1'b1;
    end else begin
      r.value = d[DW-1:0];
      r.sat   = 1'b0;
    end
    return r;
  endfunction
endpackage

// ===== sv/ndd_mul.sv =====
// Fixed-point multiplier: registered product, floor shift and saturation.
module ndd_mul (
  input  logic                clk,
  input  ndd_pkg::word_t      a,
  input  ndd_pkg::word_t      b,
  output ndd_pkg::sat_word_t  res
);
  logic signed [2*ndd_pkg::DW-1:0] prod;
  logic signed [2*ndd_pkg::DW-1:0] shifted;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

  // Arithmetic shift rounds toward minus infinity.
  assign shifted = prod >>> ndd_pkg::FRAC_BITS;

  always_comb begin
    if (shifted > 64'(ndd_pkg::S_MAX)) begin
      res.value = ndd_pkg::S_MAX;
      res.sat   = 1'b1;
    end else if (shifted < 64'(ndd_pkg::S_MIN)) begin
      res.value = ndd_pkg::S_MIN;
      res.sat   = 1'b1;
    end else begin
      res.value = shifted[ndd_pkg::DW-1:0];
      res.sat   = 1'b0;
    end
  end
endmodule

// ===== sv/ndd_div.sv =====
// Bit-serial restoring divider, quotient truncated toward zero and saturated.
module ndd_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [ndd_pkg::NUM_W-1:0]      num,
  input  logic signed [ndd_pkg::DIFF_W-1:0]     den,
  output logic                                  done,
  output ndd_pkg::sat_word_t                    res
);
  localparam int NW = ndd_pkg::NUM_W;
  localparam int RW = ndd_pkg::DIFF_W;

  logic [NW-1:0]                 quo;
  logic [RW-1:0]                 dmag;
  logic [RW-1:0]                 rem;
  logic                          neg;
  logic                          running;
  logic                          fin;
  logic [ndd_pkg::DIV_CNT_W-1:0] cnt;
  logic [RW:0]                   trial;
  logic                          qbit;

  assign trial = {rem, quo[NW-1]};
  assign qbit  = (trial >= {1'b0, dmag});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      fin     <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        quo     <= num[NW-1] ? NW'(-num) : NW'(num);
        dmag    <= den[RW-1] ? RW'(-den) : RW'(den);
        neg     <= num[NW-1] ^ den[RW-1];
        rem     <= '0;
        cnt     <= ndd_pkg::DIV_CNT_W'(NW);
        running <= 1'b1;
      end else if (running) begin
        // Advance one quotient bit.
        rem <= qbit ? RW'(trial - {1'b0, dmag}) : trial[RW-1:0];
        quo <= {quo[NW-2:0], qbit};
        cnt <= cnt - 1'b1;
        if (cnt == ndd_pkg::DIV_CNT_W'(1)) begin
          running <= 1'b0;
          fin     <= 1'b1;
        end
      end
      if (fin) begin
        done <= 1'b1;
        if (neg) begin
          if (quo > (NW'(1) << (ndd_pkg::DW - 1))) begin
            res.value <= ndd_pkg::S_MIN;
            res.sat   <= 1'b1;
          end else begin
            res.value <= ndd_pkg::DW'(-quo[ndd_pkg::DW-1:0]);
            res.sat   <= 1'b0;
          end
        end else begin
          if (quo > NW'(ndd_pkg::S_MAX)) begin
            res.value <= ndd_pkg::S_MAX;
            res.sat   <= 1'b1;
          end else begin
            res.value <= quo[ndd_pkg::DW-1:0];
            res.sat   <= 1'b0;
          end
        end
      end
    end
  end
endmodule

// ===== sv/newton_divided_difference_eval_unit.sv =====
// Top level: node stores, scratch store and the evaluation sequencer.
//
// Channel  Direction  Handshake              Payload
// command  in         start && !busy         operation, point_index, x_value, y_value
// result   out        result_valid (1 cycle) interpolated_value, status
// config   in         cfg_we                 cfg_wdata (point_count)
//
// A load is stored at its transfer and leaves the unit idle. An evaluate with n
// points computes n*(n-1)/2 divided differences and holds busy throughout; the
// bit-serial divider, started once per divided difference after its read and
// check, dominates the evaluation time.
// Reset (synchronous, active high) clears control state and sets point_count
// to 16; the stores are undefined until loaded. The receiver cannot stall:
// each result is valid on the strobe cycle only.
module newton_divided_difference_eval_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                operation,
  input  logic [ndd_pkg::IDX_W-1:0]           point_index,
  input  logic signed [ndd_pkg::DW-1:0]       x_value,
  input  logic signed [ndd_pkg::DW-1:0]       y_value,
  input  logic                                cfg_we,
  input  logic [ndd_pkg::CNT_W-1:0]           cfg_wdata,
  output logic                                result_valid,
  output logic signed [ndd_pkg::DW-1:0]       interpolated_value,
  output logic [1:0]                          status
);
  localparam int IW = ndd_pkg::IDX_W;
  localparam int CW = ndd_pkg::CNT_W;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_CP_RD  = 12'b0000_0000_0010,
    S_CP_WR  = 12'b0000_0000_0100,
    S_FAC_RD = 12'b0000_0000_1000,
    S_FAC    = 12'b0000_0001_0000,
    S_FMW1   = 12'b0000_0010_0000,
    S_FMW2   = 12'b0000_0100_0000,
    S_DD_RD  = 12'b0000_1000_0000,
    S_DD_CHK = 12'b0001_0000_0000,
    S_DD_DIV = 12'b0010_0000_0000,
    S_ACC_RD = 12'b0100_0000_0000,
    S_ACC    = 12'b1000_0000_0000
  } state_t;

  state_t state;
  logic   acc_wait; // marks the accumulate pass through the product wait states

  ndd_pkg::word_t x_mem [ndd_pkg::MAX_POINTS];
  ndd_pkg::word_t y_mem [ndd_pkg::MAX_POINTS];
  ndd_pkg::word_t s_mem [ndd_pkg::MAX_POINTS];

  ndd_pkg::word_t x_rd_a, x_rd_b, y_rd, s_rd_a, s_rd_b;
  logic [IW-1:0]  x_addr_a;

  logic [CW-1:0]  point_count;
  logic [CW-1:0]  n_eff;
  logic [IW-1:0]  i;
  logic [IW-1:0]  order;
  ndd_pkg::word_t xq;
  ndd_pkg::word_t term;
  ndd_pkg::word_t sum;
  logic           sat_any;
  ndd_pkg::word_t mul_a, mul_b;

  ndd_pkg::sat_word_t mres;
  ndd_pkg::sat_word_t dres;
  ndd_pkg::sat_word_t fac;
  ndd_pkg::sat_word_t acc;
  logic               div_start;
  logic               div_done;
  logic signed [ndd_pkg::DIFF_W-1:0] dy, dx;
  logic signed [ndd_pkg::NUM_W-1:0]  num;

  assign busy = (state != S_IDLE);

  ndd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .res (mres)
  );

  ndd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (dx),
    .done  (div_done),
    .res   (dres)
  );

  // Factor step reads x[order-1]; the divided-difference step reads x[i+order].
  assign x_addr_a = (state == S_FAC_RD) ? IW'(order - 1'b1) : IW'(i + order);

  // Node and scratch stores, read every cycle with registered data.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start && operation == ndd_pkg::OP_LOAD) begin
      x_mem[point_index] <= x_value;
      y_mem[point_index] <= y_value;
    end
    x_rd_a <= x_mem[x_addr_a];
    x_rd_b <= x_mem[i];
    y_rd   <= y_mem[i];
  end

  always_ff @(posedge clk) begin
    if (state == S_CP_WR) begin
      s_mem[i] <= y_rd;
    end else if (state == S_DD_DIV && div_done) begin
      s_mem[i] <= dres.value;
    end
    s_rd_a <= s_mem[IW'(i + 1'b1)];
    s_rd_b <= s_mem[i];
  end

  always_comb begin
    if (point_count == '0) begin
      n_eff = CW'(1);
    end else if (point_count > CW'(ndd_pkg::MAX_POINTS)) begin
      n_eff = CW'(ndd_pkg::MAX_POINTS);
    end else begin
      n_eff = point_count;
    end
  end

  assign dy  = {s_rd_a[ndd_pkg::DW-1], s_rd_a} - {s_rd_b[ndd_pkg::DW-1], s_rd_b};
  assign dx  = {x_rd_a[ndd_pkg::DW-1], x_rd_a} - {x_rd_b[ndd_pkg::DW-1], x_rd_b};
  assign num = {dy, {ndd_pkg::FRAC_BITS{1'b0}}};
  assign fac = ndd_pkg::sat_diff({xq[ndd_pkg::DW-1], xq} - {x_rd_a[ndd_pkg::DW-1], x_rd_a});
  assign acc = ndd_pkg::sat_diff({sum[ndd_pkg::DW-1], sum} + {mres.value[ndd_pkg::DW-1],
                                                            mres.value});
  assign div_start = (state == S_DD_CHK) && (dx != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      point_count  <= CW'(ndd_pkg::MAX_POINTS);
      result_valid <= 1'b0;
      acc_wait     <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_we) begin
        point_count <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (start && operation == ndd_pkg::OP_EVAL) begin
            xq      <= x_value;
            i       <= '0;
            sat_any <= 1'b0;
            state   <= S_CP_RD;
          end
        end
        S_CP_RD: state <= S_CP_WR;
        S_CP_WR: begin
          // Copy ordinates into scratch; slot 0 seeds the sum.
          if (i == '0) begin
            sum <= y_rd;
          end
          if ({1'b0, i} == CW'(n_eff - 1'b1)) begin
            term  <= ndd_pkg::Q_ONE;
            order <= IW'(1);
            if (n_eff == CW'(1)) begin
              result_valid       <= 1'b1;
              interpolated_value <= y_rd;
              status             <= ndd_pkg::ST_OK;
              state              <= S_IDLE;
            end else begin
              state <= S_FAC_RD;
            end
          end else begin
            i     <= i + 1'b1;
            state <= S_CP_RD;
          end
        end
        S_FAC_RD: state <= S_FAC;
        S_FAC: begin
          mul_a   <= term;
          mul_b   <= fac.value;
          sat_any <= sat_any | fac.sat;
          state   <= S_FMW1;
        end
        S_FMW1: state <= S_FMW2;
        S_FMW2: begin
          if (!acc_wait) begin
            term    <= mres.value;
            sat_any <= sat_any | mres.sat;
            i       <= '0;
            state   <= S_DD_RD;
          end
        end
        S_DD_RD: state <= S_DD_CHK;
        S_DD_CHK: begin
          if (dx == '0) begin
            // Duplicate node abscissa: end the evaluation with a zero result and ST_DUP.
            result_valid       <= 1'b1;
            interpolated_value <= '0;
            status             <= ndd_pkg::ST_DUP;
            state              <= S_IDLE;
          end else begin
            state <= S_DD_DIV;
          end
        end
        S_DD_DIV: begin
          if (div_done) begin
            sat_any <= sat_any | dres.sat;
            if (CW'(i) + CW'(1) == n_eff - CW'(order)) begin
              i     <= '0;
              state <= S_ACC_RD;
            end else begin
              i     <= i + 1'b1;
              state <= S_DD_RD;
            end
          end
        end
        S_ACC_RD: begin
          acc_wait <= 1'b0;
          state    <= S_ACC;
        end
        S_ACC: begin
          // On entry load the operands, then hand over to the product wait.
          if (!acc_wait) begin
            mul_a    <= term;
            mul_b    <= s_rd_b;
            acc_wait <= 1'b1;
          end else begin
            state <= S_FMW1;
          end
        end
        default: state <= S_IDLE;
      endcase
      // Accumulate once the product of term and the leading difference is out.
      if (state == S_FMW2 && acc_wait) begin
        sum     <= acc.value;
        sat_any <= sat_any | mres.sat | acc.sat;
        acc_wait <= 1'b0;
        if (CW'(order) + CW'(1) == n_eff) begin
          result_valid       <= 1'b1;
          interpolated_value <= acc.value;
          status             <= (sat_any | mres.sat | acc.sat) ? ndd_pkg::ST_SAT
                                                               : ndd_pkg::ST_OK;
          state              <= S_IDLE;
        end else begin
          order <= order + 1'b1;
          state <= S_FAC_RD;
        end
      end
    end
  end
endmodule

// ===== dv/ndd_checker.sv =====
// Checker for the divided-difference evaluator: predicts results and compares.
module ndd_checker
  import ndd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic                   busy,
  input  logic                   operation,
  input  logic [IDX_W-1:0]       point_index,
  input  logic signed [DW-1:0]   x_value,
  input  logic signed [DW-1:0]   y_value,
  input  logic                   cfg_we,
  input  logic [CNT_W-1:0]       cfg_wdata,
  input  logic                   result_valid,
  input  logic signed [DW-1:0]   interpolated_value,
  input  logic [1:0]             status,
  output int                     error_count,
  output int                     pending_count,
  output int                     result_count
);
  typedef struct packed {
    word_t      value;
    logic [1:0] code;
  } interp_t;

  word_t          model_x [MAX_POINTS];
  word_t          model_y [MAX_POINTS];
  logic [CNT_W-1:0] model_count;
  interp_t        pending_results[$];

  function automatic word_t clamp64(input longint v, inout bit sat);
    if (v > 64'sd2147483647) begin sat = 1; return S_MAX; end
    if (v < -64'sd2147483648) begin sat = 1; return S_MIN; end
    return word_t'(v);
  endfunction

  // Fixed-point product, floor rounding, clamped.
  function automatic word_t fx_mul(input word_t a, input word_t b, inout bit sat);
    longint p;
    p = longint'(a) * longint'(b);
    return clamp64(p >>> FRAC_BITS, sat);
  endfunction

  function automatic interp_t newton_eval(input word_t xq);
    word_t  diff [MAX_POINTS];
    int     n;
    bit     sat;
    word_t  term, sum, fac;
    longint dy, dx;
    interp_t r;
    n = model_count;
    if (n < 1) n = 1;
    if (n > MAX_POINTS) n = MAX_POINTS;
    sat = 0;
    for (int i = 0; i < n; i++) diff[i] = model_y[i];
    sum = diff[0];
    term = Q_ONE;
    for (int k = 1; k < n; k++) begin
      fac = clamp64(longint'(xq) - longint'(model_x[k-1]), sat);
      term = fx_mul(term, fac, sat);
      for (int i = 0; i < n - k; i++) begin
        dy = longint'(diff[i+1]) - longint'(diff[i]);
        dx = longint'(model_x[i+k]) - longint'(model_x[i]);
        if (dx == 0) begin
          r.value = '0;
          r.code  = ST_DUP;
          return r;
        end
        diff[i] = clamp64((dy * (64'sd1 <<< FRAC_BITS)) / dx, sat);
      end
      sum = clamp64(longint'(sum) + longint'(fx_mul(term, diff[0], sat)), sat);
    end
    r.value = sum;
    r.code  = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  assign pending_count = pending_results.size();

  always @(posedge clk) begin
    interp_t want;
    if (rst) begin
      model_count <= CNT_W'(16);
      error_count <= 0;
      result_count <= 0;
      pending_results.delete();
    end else begin
      if (cfg_we) model_count <= cfg_wdata;
      if (start && !busy) begin
        if (operation == OP_LOAD) begin
          model_x[point_index] <= x_value;
          model_y[point_index] <= y_value;
        end else begin
          pending_results.push_back(newton_eval(x_value));
        end
      end
      if (result_valid) begin
        result_count <= result_count + 1;
        if (pending_results.size() == 0) begin
          if (error_count < 10) $display("ERROR: unexpected result %h/%0d",
                                         interpolated_value, status);
          error_count <= error_count + 1;
        end else begin
          want = pending_results.pop_front();
          if (want.value !== interpolated_value || want.code !== status) begin
            if (error_count < 10)
              $display("ERROR: value exp %h got %h, status exp %0d got %0d",
                       want.value, interpolated_value, want.code, status);
            error_count <= error_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== dv/tb.sv =====
// Testbench top: drives commands and config, reports the verdict.
module tb;
  import ndd_pkg::*;

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic operation = OP_LOAD;
  logic [IDX_W-1:0] point_index = '0;
  logic signed [DW-1:0] x_value = '0;
  logic signed [DW-1:0] y_value = '0;
  logic cfg_we = 0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  logic busy, result_valid;
  logic signed [DW-1:0] interpolated_value;
  logic [1:0] status;
  int error_count, pending_count, result_count;
  int idle_pct;   // sender idle chance in percent for the current phase
  int evals;

  always #5 clk = ~clk;

  newton_divided_difference_eval_unit u_top (.*);

  ndd_checker u_chk (.*);

  // Idle at random first, then hold a command until its transfer; start stays high after.
  task automatic send_cmd(input logic op, input logic [IDX_W-1:0] idx,
                          input logic signed [DW-1:0] xv, input logic signed [DW-1:0] yv);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    operation <= op;
    point_index <= idx;
    x_value <= xv;
    y_value <= yv;
    // Sample busy mid-cycle so the following rising edge is the transfer.
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    if (op == OP_EVAL) evals++;
  endtask

  task automatic end_cmds();
    start <= 0;
    @(posedge clk);
  endtask

  // Wait out all outstanding results, then write point_count while idle.
  task automatic set_count(input int n);
    end_cmds();
    while (pending_count != 0 || busy) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= CNT_W'(n);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic signed [DW-1:0] rand_word();
    case ($urandom_range(3))
      0: return $urandom;
      1: return S_MAX - $urandom_range(3);
      2: return S_MIN + $urandom_range(3);
      default: return $signed($urandom_range(20 << FRAC_BITS)) - (10 << FRAC_BITS);
    endcase
  endfunction

  // Load 16 nodes with distinct x so no duplicate appears unless asked for.
  task automatic load_distinct(input bit wide);
    int base;
    base = $signed($urandom_range(64)) - 32;
    for (int i = 0; i < MAX_POINTS; i++)
      send_cmd(OP_LOAD, IDX_W'(i),
               wide ? (i << 27) - 32'sd2147483647 + $urandom_range(1000)
                    : (base + i * 2 + $urandom_range(1)) <<< FRAC_BITS,
               wide ? rand_word() : $signed($urandom_range(8 << FRAC_BITS)) - (4 << FRAC_BITS));
  endtask

  initial begin
    int n;
    idle_pct = 0;
    evals = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: extremes of nodes and queries, duplicate x, saturation.
    load_distinct(1);
    send_cmd(OP_EVAL, 0, S_MAX, 0);
    send_cmd(OP_EVAL, 4'hF, S_MIN, 0);
    set_count(1);
    send_cmd(OP_EVAL, 0, 0, 0);
    set_count(2);
    send_cmd(OP_LOAD, 1, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_cmd(OP_LOAD, 0, 32'sh80000000, 32'sh80000000);
    send_cmd(OP_EVAL, 0, 32'sh80000000, 32'sh7FFFFFFF);
    send_cmd(OP_LOAD, 1, 32'sh80000000, 0);
    send_cmd(OP_EVAL, 0, 0, 0);       // duplicate x
    set_count(0);
    send_cmd(OP_EVAL, 0, 1, 0);
    set_count(3);
    send_cmd(OP_LOAD, 0, 1 << 16, 3 << 16);
    send_cmd(OP_LOAD, 1, 2 << 16, -5 << 16);
    send_cmd(OP_LOAD, 2, -1 << 16, 7 << 16);
    send_cmd(OP_EVAL, 0, 5 << 16, 0);
    send_cmd(OP_EVAL, 0, -32'sd1, -32'sd1);

    // Random phases: small sizes mostly, the largest once.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? 58 : (ph == 2 ? 14 : 0);
      n = (ph == 3) ? 16 : $urandom_range(2, 6);
      set_count(n);
      load_distinct(ph == 2);
      for (int k = 0; k < 12; k++) begin
        if ($urandom_range(9) < 3)
          send_cmd(OP_LOAD, IDX_W'($urandom_range(n - 1)),
                   ($urandom_range(3) == 0) ? rand_word()
                                            : $signed($urandom_range(40) - 20) <<< FRAC_BITS,
                   rand_word());
        else
          send_cmd(OP_EVAL, IDX_W'($urandom), rand_word(), $urandom);
        if (k == 6) begin
          // Pause until the pipeline is drained.
          end_cmds();
          while (pending_count != 0) @(posedge clk);
        end
      end
    end

    end_cmds();
    while (pending_count != 0 || busy) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Covered %0d evaluates and %0d results over point counts 0 to 16,", evals,
             result_count);
    $display("with duplicate nodes, saturating values and random sender gaps.");
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #80000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ===== sim.f =====
sv/ndd_pkg.sv
sv/ndd_mul.sv
sv/ndd_div.sv
sv/newton_divided_difference_eval_unit.sv
dv/ndd_checker.sv
dv/tb.sv
